### design/orl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package orl_pkg;

  localparam int DEPTH_DEF = 32;
  localparam int VAL_W     = 8;
  localparam int CNT_OUT_W = 6;
  localparam int WORD_W    = 16;

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_POP    = 2'd2,
    CMD_PEEK   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_REF_SCAN,
    S_POS_SCAN
  } state_t;

  // value traveling along the chain with the scan token
  typedef struct packed {
    logic             flag;
    logic [VAL_W-1:0] val;
  } carry_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic             scan_ref;
    logic             scan_pos;
    logic             do_push;
    logic             do_pop;
    logic             do_ins;
    logic [VAL_W-1:0] val;
    logic [VAL_W-1:0] ref_val;
  } cell_ctl_t;

endpackage

`default_nettype wire

### design/orl_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module orl_cell import orl_pkg::*; #(
  parameter int CNT_W = 6,
  parameter int IDX   = 0
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cell_ctl_t        ctl,
  input  wire logic [CNT_W-1:0] count,
  input  wire logic [VAL_W-1:0] left_val,
  input  wire logic             left_shift,
  input  wire logic [VAL_W-1:0] right_val,
  input  wire logic             tok_in,
  input  wire carry_t           car_in,
  output logic                  tok_out,
  output carry_t                car_out,
  output logic [VAL_W-1:0]      val_out,
  output logic                  shift_out
);

  logic [VAL_W-1:0] entry_r;
  logic             tok_r;
  carry_t           car_r;
  carry_t           car_nxt;
  logic             shift_r;
  logic             occ;
  logic             lt;
  logic             eq;

  always_comb begin
    occ = count > CNT_W'(IDX);
    lt  = occ && (entry_r < ctl.val);
    eq  = occ && (entry_r == ctl.ref_val);
    if (ctl.scan_ref) begin
      // keep the last smaller entry seen from the head
      car_nxt = lt ? carry_t'{flag: 1'b1, val: entry_r} : car_in;
    end else begin
      car_nxt = carry_t'{flag: car_in.flag | eq, val: car_in.val};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r   <= 1'b0;
      shift_r <= 1'b0;
    end else begin
      tok_r <= tok_in;
      // flag arriving here: no smaller entry exists, or some entry to the left already matched the reference
      if (tok_in && ctl.scan_pos) begin
        shift_r <= car_in.flag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok_in) begin
      car_r <= car_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.do_push) begin
      entry_r <= left_val;
    end else if (ctl.do_pop) begin
      entry_r <= right_val;
    end else if (ctl.do_ins && shift_r) begin
      entry_r <= left_shift ? left_val : ctl.val;
    end
  end

  assign tok_out   = tok_r;
  assign car_out   = car_r;
  assign val_out   = entry_r;
  assign shift_out = shift_r;

endmodule

`default_nettype wire

### design/ordered_route_list.sv
`timescale 1ns / 1ps
`default_nettype none
// Bounded list of 8-bit codes, head first, with push, ordered insert, pop and peek.
// Input words on in_* (tvalid/tready), one result word per command on out_*.
// in_tdata : [1:0] command, [9:2] value, [15:10] zero.
// out_tdata: [1:0] status, [9:2] out_value, [15:10] count after the command.
// The list lives in a row of DEPTH cells; cell 0 holds the head. Push and pop
// shift the whole row at once; peek reads cell 0.
// Push, pop, peek and any full-list drop: result registered in the cycle after
// acceptance, and a new word can be taken every cycle while out_tready is high.
// Ordered insert: a token walks the cell chain twice, one cell per cycle,
// first to find the reference value and then to mark the insert point; the
// result is loaded when the second pass leaves the last cell, and in_tready
// stays low until then.
// The result sits in an output register; a new word is accepted while the
// previous result is being taken, and a stalled out_tready holds the result
// and blocks further input.
// Reset (rst_n low, synchronous) empties the list and drops any pending result.
module ordered_route_list import orl_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [WORD_W-1:0] in_tdata,   // [1:0] command, [9:2] value
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [WORD_W-1:0]      out_tdata   // [1:0] status, [9:2] out_value, [15:10] count
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  state_t           state_r;
  state_t           state_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [VAL_W-1:0] v_r;
  logic [VAL_W-1:0] ref_r;
  logic             found_r;
  logic             start_r;
  logic             start_nxt;

  logic             out_valid_r;
  status_t          out_status_r;
  logic [VAL_W-1:0] out_val_r;
  logic [CNT_W-1:0] out_cnt_r;
  logic             out_load;
  status_t          out_status_nxt;
  logic [VAL_W-1:0] out_val_nxt;

  cmd_t             in_cmd;
  logic [VAL_W-1:0] in_val;
  logic             in_acc;
  logic             full;
  logic             empty;
  logic             last_tok;
  cell_ctl_t        ctl;

  logic             tok   [DEPTH+1];
  carry_t           car   [DEPTH+1];
  logic [VAL_W-1:0] val   [DEPTH];
  logic             shift [DEPTH];

  assign in_cmd    = cmd_t'(in_tdata[1:0]);
  assign in_val    = in_tdata[VAL_W+1:2];
  assign full      = count_r == CNT_W'(DEPTH);
  assign empty     = count_r == '0;
  assign last_tok  = tok[DEPTH];
  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && in_cmd == CMD_INSERT && !full) begin
          state_nxt = S_REF_SCAN;
        end
      end
      S_REF_SCAN: begin
        if (last_tok) begin
          state_nxt = S_POS_SCAN;
        end
      end
      S_POS_SCAN: begin
        if (last_tok) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs of the controller
  always_comb begin
    ctl            = '0;
    ctl.scan_ref   = state_r == S_REF_SCAN;
    ctl.scan_pos   = state_r == S_POS_SCAN;
    ctl.val        = (state_r == S_IDLE) ? in_val : v_r;
    ctl.ref_val    = ref_r;
    out_load       = 1'b0;
    out_status_nxt = STAT_OK;
    out_val_nxt    = '0;
    count_nxt      = count_r;
    start_nxt      = 1'b0;
    if (in_acc) begin
      unique case (in_cmd)
        CMD_PUSH: begin
          out_load = 1'b1;
          if (full) begin
            out_status_nxt = STAT_FULL;
          end else begin
            ctl.do_push = 1'b1;
            count_nxt   = count_r + 1'b1;
          end
        end
        CMD_INSERT: begin
          if (full) begin
            out_load       = 1'b1;
            out_status_nxt = STAT_FULL;
          end else begin
            start_nxt = 1'b1;
          end
        end
        CMD_POP: begin
          out_load = 1'b1;
          if (empty) begin
            out_status_nxt = STAT_EMPTY;
          end else begin
            ctl.do_pop  = 1'b1;
            out_val_nxt = val[0];
            count_nxt   = count_r - 1'b1;
          end
        end
        CMD_PEEK: begin
          out_load = 1'b1;
          if (empty) begin
            out_status_nxt = STAT_EMPTY;
          end else begin
            out_val_nxt = val[0];
          end
        end
        default: out_load = 1'b0;
      endcase
    end else if (state_r == S_REF_SCAN && last_tok) begin
      start_nxt = 1'b1;
    end else if (state_r == S_POS_SCAN && last_tok) begin
      ctl.do_ins = 1'b1;
      out_load   = 1'b1;
      count_nxt  = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      start_r <= start_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_REF_SCAN && last_tok) begin
        found_r <= car[DEPTH].flag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      v_r <= in_val;
    end
    if (state_r == S_REF_SCAN && last_tok) begin
      ref_r <= car[DEPTH].val;
    end
    if (out_load) begin
      out_status_r <= out_status_nxt;
      out_val_r    <= out_val_nxt;
      out_cnt_r    <= count_nxt;
    end
  end

  // token enters cell 0; the second pass starts with "no smaller entry" as the flag
  assign tok[0] = start_r;
  assign car[0] = (state_r == S_POS_SCAN) ? carry_t'{flag: ~found_r, val: '0} : '0;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [VAL_W-1:0] lv;
    logic             ls;
    logic [VAL_W-1:0] rv;

    if (k == 0) begin : g_head
      assign lv = ctl.val;
      assign ls = 1'b0;
    end else begin : g_mid
      assign lv = val[k-1];
      assign ls = shift[k-1];
    end

    if (k == DEPTH - 1) begin : g_tail
      assign rv = val[k];
    end else begin : g_body
      assign rv = val[k+1];
    end

    orl_cell #(
      .CNT_W (CNT_W),
      .IDX   (k)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .count      (count_r),
      .left_val   (lv),
      .left_shift (ls),
      .right_val  (rv),
      .tok_in     (tok[k]),
      .car_in     (car[k]),
      .tok_out    (tok[k+1]),
      .car_out    (car[k+1]),
      .val_out    (val[k]),
      .shift_out  (shift[k])
    );
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {CNT_OUT_W'(out_cnt_r), out_val_r, out_status_r};

endmodule

`default_nettype wire

### verif/ordered_route_list_test.sv
`timescale 1ns / 1ps

module ordered_route_list_test;
  import orl_pkg::*;

  localparam int LIST_DEPTH  = DEPTH_DEF;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    status_t          status;
    logic [VAL_W-1:0] value;
    logic [5:0]       count;
  } route_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [WORD_W-1:0] in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [WORD_W-1:0] out_tdata;

  // predicted list contents, head at index 0
  logic [VAL_W-1:0] route_list[$];
  route_result_t    pending_results[$];

  int  fail_count = 0;
  int  cycle_count = 0;
  int  rx_hold = 0;
  bit  in_gap_en = 1'b1;
  bit  out_stall_en = 1'b1;

  ordered_route_list #(.DEPTH(LIST_DEPTH)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("ordered_route_list verification failed");
        $finish;
      end
    end
  end

  // Slot after the first entry (from the head) equal to the tail-most entry
  // smaller than v; head when nothing is smaller.
  function automatic int ordered_slot(logic [VAL_W-1:0] v);
    bit               found;
    logic [VAL_W-1:0] ref_code;
    found = 1'b0;
    ref_code = '0;
    foreach (route_list[i]) begin
      if (route_list[i] < v) begin
        found = 1'b1;
        ref_code = route_list[i];
      end
    end
    if (!found) return 0;
    foreach (route_list[i]) begin
      if (route_list[i] == ref_code) return i + 1;
    end
    return 0;
  endfunction

  function automatic route_result_t apply_route_cmd(cmd_t cmd, logic [VAL_W-1:0] v);
    route_result_t res;
    res.status = STAT_OK;
    res.value = '0;
    case (cmd)
      CMD_PUSH, CMD_INSERT: begin
        if (route_list.size() >= LIST_DEPTH) begin
          res.status = STAT_FULL;
        end else if (cmd == CMD_PUSH) begin
          route_list.push_front(v);
        end else begin
          route_list.insert(ordered_slot(v), v);
        end
      end
      CMD_POP: begin
        if (route_list.size() == 0) res.status = STAT_EMPTY;
        else res.value = route_list.pop_front();
      end
      default: begin
        if (route_list.size() == 0) res.status = STAT_EMPTY;
        else res.value = route_list[0];
      end
    endcase
    res.count = 6'(route_list.size());
    return res;
  endfunction

  // receiver: long hold-off on request, otherwise random stall bursts
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_tready <= 1'b0;
        rx_hold--;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (out_stall_en && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        stall_left = $urandom_range(0, 7);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // result checker
  initial begin
    route_result_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          $error("result word with nothing expected: %h", out_tdata);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_tdata[1:0] !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, out_tdata[1:0]);
            fail_count++;
          end
          if (out_tdata[9:2] !== want.value) begin
            $error("out_value mismatch: expected %0d, actual %0d", want.value, out_tdata[9:2]);
            fail_count++;
          end
          if (out_tdata[15:10] !== want.count) begin
            $error("count mismatch: expected %0d, actual %0d", want.count, out_tdata[15:10]);
            fail_count++;
          end
        end
      end
    end
  end

  task automatic send_word(cmd_t cmd, logic [VAL_W-1:0] v);
    int gap;
    if (in_gap_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 8);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {6'd0, v, cmd};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(apply_route_cmd(cmd, v));
  endtask

  task automatic wait_all_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_list();
    send_word(CMD_POP, 8'd0);
    send_word(CMD_PEEK, 8'hff);
    send_word(CMD_INSERT, 8'd0);   // insert into empty list
    send_word(CMD_PEEK, 8'd0);
    send_word(CMD_POP, 8'd0);
    send_word(CMD_POP, 8'd0);
    wait_all_results();
  endtask

  task automatic test_ordered_insert();
    send_word(CMD_PUSH, 8'd50);
    send_word(CMD_PUSH, 8'd10);
    send_word(CMD_PUSH, 8'd30);
    send_word(CMD_INSERT, 8'd40);  // ref is 10, the smaller entry nearer the tail
    send_word(CMD_INSERT, 8'd5);   // nothing smaller -> head
    send_word(CMD_INSERT, 8'd255);
    send_word(CMD_INSERT, 8'd0);   // zero never beats an entry
    send_word(CMD_PUSH, 8'd10);
    send_word(CMD_INSERT, 8'd20);  // duplicate ref, first match from head wins
    send_word(CMD_INSERT, 8'd1);   // stored zero used as ref
    send_word(CMD_PUSH, 8'd255);
    send_word(CMD_INSERT, 8'd255);
    send_word(CMD_PEEK, 8'd0);
    send_word(CMD_POP, 8'd0);
    send_word(CMD_POP, 8'd0);
    wait_all_results();
  endtask

  task automatic test_full_list();
    while (route_list.size() < LIST_DEPTH) begin
      if ($urandom_range(0, 1)) send_word(CMD_PUSH, 8'($urandom_range(0, 255)));
      else send_word(CMD_INSERT, 8'($urandom_range(0, 255)));
    end
    send_word(CMD_PUSH, 8'hff);
    send_word(CMD_INSERT, 8'h01);
    send_word(CMD_PEEK, 8'd0);
    while (route_list.size() > 0) send_word(CMD_POP, 8'd0);
    send_word(CMD_PEEK, 8'd0);
    wait_all_results();
  endtask

  task automatic test_backpressure();
    rx_hold = 300;
    in_gap_en = 1'b0;
    repeat (12) send_word(CMD_PUSH, 8'($urandom_range(0, 255)));
    wait_all_results();
    repeat (12) send_word(CMD_POP, 8'd0);
    wait_all_results();
    in_gap_en = 1'b1;
  endtask

  task automatic test_random_mix(int n_words);
    int               r;
    int               add_pct;
    logic [VAL_W-1:0] v;
    for (int k = 0; k < n_words; k++) begin
      add_pct = (route_list.size() < LIST_DEPTH / 2) ? 60 : 45;
      r = $urandom_range(0, 99);
      // small codes make duplicate refs common
      if ($urandom_range(0, 2) == 0) v = 8'($urandom_range(1, 6));
      else v = 8'($urandom_range(0, 255));
      if (r < add_pct / 3) send_word(CMD_PUSH, v);
      else if (r < add_pct) send_word(CMD_INSERT, v);
      else if (r < add_pct + 30) send_word(CMD_POP, v);
      else send_word(CMD_PEEK, v);
    end
    wait_all_results();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_list();
    test_ordered_insert();
    test_full_list();
    test_backpressure();
    test_random_mix(220);
    in_gap_en = 1'b0;
    out_stall_en = 1'b0;
    test_random_mix(120);

    repeat (2 * LIST_DEPTH + 8) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("ordered_route_list verification clean");
    end else begin
      $display("ordered_route_list verification failed");
    end
    $finish;
  end

endmodule
